FILE: src/mfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfu_pkg
// Shared constants for the most-frequently-used page replacement unit.
// ----------------------------------------------------------------------------
package mfu_pkg;

    localparam int PAGE_PORT_W  = 16;
    localparam int INDEX_PORT_W = 3;
    localparam int FAULT_W      = 16;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

endpackage

FILE: src/mfu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/mfu_page_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfu_page_replacement_unit
// Most-frequently-used page replacement over a small set of frames.
// A new page word is taken only while idle: each word runs a walk that
// reads one frame entry per cycle from the frame RAM, then a write-back
// that waits until the result register is free.
// Reset: synchronous active-low aresetn clears valid bits, fault count and
// the frame limit (to 8); no RAM clearing pass.
// ----------------------------------------------------------------------------
module mfu_page_replacement_unit
    import mfu_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PAGE_PORT_W-1:0]  s_page_number,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic [INDEX_PORT_W-1:0] m_frame_index,
    output logic                    m_evicted,
    output logic [PAGE_PORT_W-1:0]  m_evicted_page,
    output logic [FAULT_W-1:0]      m_fault_count
);

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int WORD_W = PAGE_BITS + COUNT_BITS;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_WRITE} state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        cfg_frames_reg;
    logic [FRAMES-1:0]       valid_reg;
    logic [PAGE_BITS-1:0]    page_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic [IDX_W-1:0]        eval_idx_reg;
    logic                    pend_reg;
    logic [FAULT_W-1:0]      faults_reg;

    logic                    found_reg,     found_next;
    logic [IDX_W-1:0]        hit_at_reg,    hit_at_next;
    logic [COUNT_BITS-1:0]   hit_count_reg, hit_count_next;
    logic                    empty_reg,     empty_next;
    logic [IDX_W-1:0]        empty_at_reg,  empty_at_next;
    logic [IDX_W-1:0]        max_at_reg,    max_at_next;
    logic [COUNT_BITS-1:0]   max_count_reg, max_count_next;
    logic [PAGE_BITS-1:0]    max_page_reg,  max_page_next;

    logic                    m_valid_reg;
    logic                    m_hit_reg;
    logic [INDEX_PORT_W-1:0] m_frame_index_reg;
    logic                    m_evicted_reg;
    logic [PAGE_PORT_W-1:0]  m_evicted_page_reg;
    logic [FAULT_W-1:0]      m_fault_count_reg;

    logic [31:0]             cfg_ext;
    logic [IDX_W-1:0]        last_idx;
    logic [WORD_W-1:0]       rd_word;
    logic [PAGE_BITS-1:0]    rd_page;
    logic [COUNT_BITS-1:0]   rd_count;
    logic                    rd_valid;
    logic [IDX_W-1:0]        frame;
    logic [COUNT_BITS-1:0]   new_count;
    logic [WORD_W-1:0]       wr_word;
    logic                    out_free;
    logic                    ram_we;
    logic [FAULT_W-1:0]      faults_new;

    // managed frame count clamped to 1..FRAMES
    always_comb begin
        cfg_ext = 32'(cfg_frames_reg);
        if (cfg_ext == 32'd0) begin
            last_idx = '0;
        end else if (cfg_ext > 32'(FRAMES)) begin
            last_idx = IDX_W'(FRAMES - 1);
        end else begin
            last_idx = IDX_W'(cfg_ext - 32'd1);
        end
    end

    mfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (frame),
        .wdata (wr_word),
        .raddr (addr_reg),
        .rdata (rd_word)
    );

    assign rd_page  = rd_word[WORD_W-1:COUNT_BITS];
    assign rd_count = rd_word[COUNT_BITS-1:0];
    assign rd_valid = valid_reg[eval_idx_reg];

    // per-entry evaluation of the walk
    always_comb begin
        found_next     = found_reg;
        hit_at_next    = hit_at_reg;
        hit_count_next = hit_count_reg;
        empty_next     = empty_reg;
        empty_at_next  = empty_at_reg;
        max_at_next    = max_at_reg;
        max_count_next = max_count_reg;
        max_page_next  = max_page_reg;
        if (state_reg == S_IDLE) begin
            found_next = 1'b0;
            empty_next = 1'b0;
        end else if (pend_reg) begin
            if (rd_valid) begin
                if (!found_reg && rd_page == page_reg) begin
                    found_next     = 1'b1;
                    hit_at_next    = eval_idx_reg;
                    hit_count_next = rd_count;
                end
            end else if (!empty_reg) begin
                empty_next    = 1'b1;
                empty_at_next = eval_idx_reg;
            end
            if (eval_idx_reg == '0 || (rd_valid && rd_count > max_count_reg)) begin
                max_at_next    = eval_idx_reg;
                max_count_next = rd_count;
                max_page_next  = rd_page;
            end
        end
    end

    // write-back selection
    always_comb begin
        if (found_reg) begin
            frame = hit_at_reg;
        end else if (empty_reg) begin
            frame = empty_at_reg;
        end else begin
            frame = max_at_reg;
        end
        if (!found_reg) begin
            new_count = COUNT_BITS'(1);
        end else if (hit_count_reg != '1) begin
            new_count = hit_count_reg + COUNT_BITS'(1);
        end else begin
            new_count = hit_count_reg;
        end
        if (!found_reg && faults_reg != '1) begin
            faults_new = faults_reg + FAULT_W'(1);
        end else begin
            faults_new = faults_reg;
        end
        wr_word  = {page_reg, new_count};
        out_free = !m_valid_reg || m_ready;
        ram_we   = (state_reg == S_WRITE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cfg_frames_reg <= CFG_FRAMES_RESET;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            faults_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_frames_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready && !ram_we) begin
                m_valid_reg <= 1'b0;
            end
            pend_reg      <= (state_reg == S_SCAN);
            found_reg     <= found_next;
            hit_at_reg    <= hit_at_next;
            hit_count_reg <= hit_count_next;
            empty_reg     <= empty_next;
            empty_at_reg  <= empty_at_next;
            max_at_reg    <= max_at_next;
            max_count_reg <= max_count_next;
            max_page_reg  <= max_page_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        page_reg  <= PAGE_BITS'(s_page_number);
                        addr_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    eval_idx_reg <= addr_reg;
                    if (addr_reg == last_idx) begin
                        state_reg <= S_LAST;
                    end else begin
                        addr_reg <= addr_reg + IDX_W'(1);
                    end
                end
                S_LAST: begin
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (out_free) begin
                        valid_reg[frame]   <= 1'b1;
                        faults_reg         <= faults_new;
                        m_valid_reg        <= 1'b1;
                        m_hit_reg          <= found_reg;
                        m_frame_index_reg  <= INDEX_PORT_W'(frame);
                        m_evicted_reg      <= !found_reg && !empty_reg;
                        m_evicted_page_reg <= (!found_reg && !empty_reg) ?
                                              PAGE_PORT_W'(max_page_reg) : '0;
                        m_fault_count_reg  <= faults_new;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_frame_index  = m_frame_index_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_evicted_page = m_evicted_page_reg;
    assign m_fault_count  = m_fault_count_reg;

endmodule

FILE: src/mfu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfu_checker
// Port-level checks for the page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
module mfu_checker
    import mfu_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_hit,
    input logic                    m_evicted,
    input logic [PAGE_PORT_W-1:0]  m_evicted_page,
    input logic [FAULT_W-1:0]      m_fault_count
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fault_count))
        else $error("stalled result word changed");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted)
        else $error("hit word reports an eviction");

    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted |-> m_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_fault_count != '0)
        else $error("miss word with zero fault count");

endmodule

bind mfu_page_replacement_unit mfu_checker u_mfu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hit          (m_hit),
    .m_evicted      (m_evicted),
    .m_evicted_page (m_evicted_page),
    .m_fault_count  (m_fault_count)
);

FILE: verif/mfu_page_replacement_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfu_page_replacement_unit_test
// Self-checking bench for the most-frequently-used page replacement unit.
// A frame table tracker predicts hit, frame, eviction and fault count for
// every accepted page word and checks result words in order. Stimulus runs
// a directed opening, random phases over many frame limits, most with
// bursty handshakes, and one long output stall, then a closing phase with all
// frames managed and no idling.
// ----------------------------------------------------------------------------
module mfu_page_replacement_unit_test;
    import mfu_pkg::*;

    localparam int FRAME_COUNT = 8;
    localparam int COUNT_W     = 16;

    typedef struct packed {
        logic                    hit;
        logic [INDEX_PORT_W-1:0] frame;
        logic                    evicted;
        logic [PAGE_PORT_W-1:0]  evicted_page;
        logic [FAULT_W-1:0]      faults;
    } outcome_t;

    class frame_table_tracker;
        logic [PAGE_PORT_W-1:0] resident [FRAME_COUNT];
        bit                     valid_bits [FRAME_COUNT];
        logic [COUNT_W-1:0]     uses [FRAME_COUNT];
        logic [FAULT_W-1:0]     faults;
        logic [CFG_W-1:0]       frames_setting;
        outcome_t               pending_outcomes [$];
        int                     failures;

        function new();
            for (int i = 0; i < FRAME_COUNT; i++) begin
                valid_bits[i] = 1'b0;
                uses[i] = '0;
            end
            faults = '0;
            frames_setting = CFG_FRAMES_RESET;
            failures = 0;
        endfunction

        function void note_reference(logic [PAGE_PORT_W-1:0] page);
            int span;
            bit found;
            bit have_empty;
            int hit_at;
            int empty_at;
            int max_at;
            outcome_t o;
            span = int'(frames_setting);
            if (span < 1) span = 1;
            if (span > FRAME_COUNT) span = FRAME_COUNT;
            found = 1'b0;
            have_empty = 1'b0;
            hit_at = 0;
            empty_at = 0;
            max_at = 0;
            for (int i = 0; i < span; i++) begin
                if (valid_bits[i]) begin
                    if (!found && resident[i] == page) begin
                        found = 1'b1;
                        hit_at = i;
                    end
                end else if (!have_empty) begin
                    have_empty = 1'b1;
                    empty_at = i;
                end
                if (uses[i] > uses[max_at]) max_at = i;
            end
            o = '0;
            if (found) begin
                o.hit = 1'b1;
                o.frame = INDEX_PORT_W'(hit_at);
                if (uses[hit_at] != '1) uses[hit_at] = uses[hit_at] + 1'b1;
            end else begin
                if (have_empty) begin
                    o.frame = INDEX_PORT_W'(empty_at);
                end else begin
                    o.frame = INDEX_PORT_W'(max_at);
                    o.evicted = 1'b1;
                    o.evicted_page = resident[max_at];
                end
                resident[o.frame] = page;
                valid_bits[o.frame] = 1'b1;
                uses[o.frame] = COUNT_W'(1);
                if (faults != '1) faults = faults + 1'b1;
            end
            o.faults = faults;
            pending_outcomes.push_back(o);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            failures++;
            if (failures <= 50)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                failures++;
                if (failures <= 50)
                    $display("%0t ns: result word with none expected, expected none, actual %h",
                             $time, got);
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.hit !== want.hit) report("hit", 32'(want.hit), 32'(got.hit));
            if (got.frame !== want.frame)
                report("frame_index", 32'(want.frame), 32'(got.frame));
            if (got.evicted !== want.evicted)
                report("evicted", 32'(want.evicted), 32'(got.evicted));
            if (got.evicted_page !== want.evicted_page)
                report("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
            if (got.faults !== want.faults)
                report("fault_count", 32'(want.faults), 32'(got.faults));
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [PAGE_PORT_W-1:0]  s_page_number = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_hit;
    logic [INDEX_PORT_W-1:0] m_frame_index;
    logic                    m_evicted;
    logic [PAGE_PORT_W-1:0]  m_evicted_page;
    logic [FAULT_W-1:0]      m_fault_count;

    frame_table_tracker tracker = new();
    bit                 idling_on = 1'b0;
    bit                 hold_request = 1'b0;
    logic [PAGE_PORT_W-1:0] hot_pages [12];

    mfu_page_replacement_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_page_number (s_page_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_frame_index (m_frame_index),
        .m_evicted     (m_evicted),
        .m_evicted_page(m_evicted_page),
        .m_fault_count (m_fault_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: checks words and throttles m_ready
    initial begin : result_sink
        int stall_left;
        int hold_left;
        outcome_t got;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.hit = m_hit;
                got.frame = m_frame_index;
                got.evicted = m_evicted;
                got.evicted_page = m_evicted_page;
                got.faults = m_fault_count;
                tracker.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_page(input logic [PAGE_PORT_W-1:0] page);
        s_valid <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        tracker.note_reference(page);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.frames_setting = value;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] setting, input int count,
                             input bit with_idle, input bit with_hold);
        int span;
        drain();
        set_frames(setting);
        idling_on = with_idle;
        if (with_hold) hold_request = 1'b1;
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < 12; i++) hot_pages[i] = PAGE_PORT_W'($urandom);
        end
        span = $urandom_range(2, 11);
        repeat (count) begin
            if ($urandom_range(0, 9) < 7)
                send_page(hot_pages[$urandom_range(0, span)]);
            else
                send_page(PAGE_PORT_W'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_setting [12];
        phase_setting = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd8,
                          4'd2, 4'd9, 4'd5, 4'd4, 4'd7, 4'd6};
        for (int i = 0; i < 12; i++) hot_pages[i] = PAGE_PORT_W'($urandom);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fill, hits, eviction by highest count and by tie
        idling_on = 1'b1;
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        for (int p = 1; p <= 6; p++) send_page(PAGE_PORT_W'(p));
        send_page(16'h8000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        // limit of zero acts as one frame, frames above it are hidden
        drain();
        set_frames(4'd0);
        send_page(16'hAAAA);
        send_page(16'h0002);
        // limit above the frame count acts as all frames
        drain();
        set_frames(4'd15);
        send_page(16'h0002);
        send_page(16'h0006);
        send_page(16'h1234);
        drain();
        set_frames(4'd1);
        send_page(16'h0006);
        send_page(16'h0006);
        drain();
        set_frames(4'd8);
        send_page(16'h0006);
        send_page(16'h7FFF);

        for (int k = 0; k < 12; k++) begin
            run_phase(phase_setting[k], 140, (k % 4) != 3, k == 2);
        end
        run_phase(CFG_W'($urandom_range(0, 15)), 60, 1'b1, 1'b0);

        // closing phase with all frames managed and no idling
        drain();
        idling_on = 1'b0;
        set_frames(4'd8);
        send_page(16'h0F0F);
        repeat (40) send_page(PAGE_PORT_W'($urandom));

        drain();
        if (tracker.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mfu_pkg.sv
src/mfu_ram.sv
src/mfu_page_replacement_unit.sv
src/mfu_checker.sv
verif/mfu_page_replacement_unit_test.sv
